[rtl/mfr_pkg.sv]
package mfr_pkg;

	localparam logic [7:0] START_BYTE  = 8'h68;
	localparam logic [7:0] DATA_OFFSET = 8'h33;
	localparam logic [7:0] END_BYTE    = 8'h16;

	localparam logic [47:0] ADDR_BROADCAST = 48'h9999_9999_9999;
	localparam logic [47:0] ADDR_WILDCARD  = 48'hAAAA_AAAA_AAAA;
	localparam logic [47:0] ADDR_RESET     = 48'h0000_0000_0001;

	localparam int unsigned ADDR_BYTES = 6;

	// frame phases
	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_ADDR   = 3'd1;
	localparam logic [2:0] PH_START2 = 3'd2;
	localparam logic [2:0] PH_CTRL   = 3'd3;
	localparam logic [2:0] PH_LEN    = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_SUM    = 3'd6;
	localparam logic [2:0] PH_END    = 3'd7;

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// reject causes
	localparam logic [1:0] CAUSE_NONE     = 2'd0;
	localparam logic [1:0] CAUSE_CHECKSUM = 2'd1;
	localparam logic [1:0] CAUSE_END      = 2'd2;
	localparam logic [1:0] CAUSE_START2   = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [7:0] index;
		logic [7:0] ctrl;
		logic [7:0] length;
		logic       own_match;
		logic       bcast_match;
		logic       wild_match;
		logic [1:0] cause;
	} res_t;

endpackage

[rtl/meter_frame_receiver.sv]
// result path: a byte is registered in the input register on acceptance, and its
//   result, if any, is shown from the result register (via the skid entry if held)
// throughput: one byte per cycle while in_stall is low; a two-entry result buffer
//   keeps the input open while a finished result waits to be taken
// reset: arst_n clears the parser to hunting and sets own_address to 1
module meter_frame_receiver
	import mfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  data_value,
	output logic [7:0]  data_index,
	output logic [7:0]  ctrl_code,
	output logic [7:0]  data_length,
	output logic        own_match,
	output logic        broadcast_match,
	output logic        wildcard_match,
	output logic [1:0]  reject_cause
);

	logic [47:0] own_addr_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic [2:0]  phase_q, phase_d;
	logic [47:0] addr_q, addr_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;

	logic        res_vld;
	res_t        res;

	logic        out_vld_q;
	res_t        out_q;
	logic        skid_vld_q;
	res_t        skid_q;

	logic        adv;
	logic        out_take;
	logic [7:0]  count_inc;
	logic [7:0]  sum_add;

	assign adv       = valid_s1 && !skid_vld_q;
	assign in_stall  = valid_s1 && skid_vld_q;
	assign out_take  = out_vld_q && !out_stall;
	assign count_inc = count_q + 8'd1;
	assign sum_add   = sum_q + byte_s1;

	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		ctrl_d  = ctrl_q;
		len_d   = len_q;
		count_d = count_q;
		sum_d   = sum_q;
		res_vld = 1'b0;
		res     = '0;
		unique case (phase_q)
			PH_ADDR: begin
				addr_d[{count_q[2:0], 3'b000} +: 8] = byte_s1;
				sum_d   = sum_add;
				count_d = count_inc;
				if (count_inc >= 8'(ADDR_BYTES)) begin
					phase_d = PH_START2;
				end
			end
			PH_START2: begin
				if (byte_s1 != START_BYTE) begin
					res_vld   = 1'b1;
					res.kind  = KIND_REJECT;
					res.cause = CAUSE_START2;
					phase_d   = PH_HUNT;
				end else begin
					sum_d   = sum_add;
					phase_d = PH_CTRL;
				end
			end
			PH_CTRL: begin
				ctrl_d  = byte_s1;
				sum_d   = sum_add;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = byte_s1;
				sum_d   = sum_add;
				count_d = '0;
				phase_d = (byte_s1 == 8'd0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				res_vld   = 1'b1;
				res.kind  = KIND_DATA;
				res.value = byte_s1 - DATA_OFFSET;
				res.index = count_q;
				sum_d     = sum_add;
				count_d   = count_inc;
				if (count_inc >= len_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				if (byte_s1 != sum_q) begin
					res_vld   = 1'b1;
					res.kind  = KIND_REJECT;
					res.cause = CAUSE_CHECKSUM;
					phase_d   = PH_HUNT;
				end else begin
					phase_d = PH_END;
				end
			end
			PH_END: begin
				res_vld = 1'b1;
				phase_d = PH_HUNT;
				if (byte_s1 != END_BYTE) begin
					res.kind  = KIND_REJECT;
					res.cause = CAUSE_END;
				end else begin
					res.kind        = KIND_ACCEPT;
					res.ctrl        = ctrl_q;
					res.length      = len_q;
					res.own_match   = (addr_q == own_addr_q);
					res.bcast_match = (addr_q == ADDR_BROADCAST);
					res.wild_match  = (addr_q == ADDR_WILDCARD);
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		// a start byte seen while hunting or on a failed beat opens a new frame
		if (byte_s1 == START_BYTE && (phase_q == PH_HUNT
				|| (res_vld && res.kind == KIND_REJECT))) begin
			phase_d = PH_ADDR;
			addr_d  = '0;
			count_d = '0;
			sum_d   = START_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= ADDR_RESET;
		end else if (cfg_write) begin
			own_addr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			addr_q  <= '0;
			ctrl_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			ctrl_q  <= ctrl_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	// output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || out_take) begin
				out_vld_q  <= skid_vld_q || (adv && res_vld);
				skid_vld_q <= 1'b0;
			end else if (adv && res_vld) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (adv && res_vld) begin
			skid_q <= res;
		end
	end

	assign out_valid       = out_vld_q;
	assign out_kind        = out_q.kind;
	assign data_value      = out_q.value;
	assign data_index      = out_q.index;
	assign ctrl_code       = out_q.ctrl;
	assign data_length     = out_q.length;
	assign own_match       = out_q.own_match;
	assign broadcast_match = out_q.bcast_match;
	assign wildcard_match  = out_q.wild_match;
	assign reject_cause    = out_q.cause;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held with output register empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && out_stall))
		else $error("skid entry filled while output was free");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_ACCEPT
			|| out_kind == KIND_REJECT))
		else $error("illegal result kind");

	a_cause_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_kind == KIND_REJECT) == (reject_cause != CAUSE_NONE)))
		else $error("reject cause inconsistent with result kind");

	a_data_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == PH_DATA) |-> (count_q < len_q))
		else $error("data beat beyond frame length");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import mfr_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BYTES   = 600;

	typedef enum {FLAW_NONE, FLAW_START2, FLAW_SUM, FLAW_END} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  data_value;
	logic [7:0]  data_index;
	logic [7:0]  ctrl_code;
	logic [7:0]  data_length;
	logic        own_match;
	logic        broadcast_match;
	logic        wildcard_match;
	logic [1:0]  reject_cause;

	meter_frame_receiver dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_kind        (out_kind),
		.data_value      (data_value),
		.data_index      (data_index),
		.ctrl_code       (ctrl_code),
		.data_length     (data_length),
		.own_match       (own_match),
		.broadcast_match (broadcast_match),
		.wildcard_match  (wildcard_match),
		.reject_cause    (reject_cause)
	);

	always #10 clk = ~clk;

	// parser copy kept by the bench
	logic [2:0]  frame_phase = PH_HUNT;
	logic [47:0] addr_acc    = '0;
	logic [7:0]  ctrl_seen   = '0;
	logic [7:0]  len_seen    = '0;
	logic [7:0]  byte_cnt    = '0;
	logic [7:0]  frame_sum   = '0;
	logic [47:0] own_addr    = ADDR_RESET;

	res_t pending_results[$];
	int   mismatch_count = 0;
	int   bytes_sent = 0;
	int   quiet_cycles = 0;
	bit   gaps_on = 1'b1;
	bit   hold_request = 1'b0;

	function automatic void open_frame();
		frame_sum   = START_BYTE;
		byte_cnt    = '0;
		addr_acc    = '0;
		frame_phase = PH_ADDR;
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		res_t       r;
		bit         produced;
		logic [1:0] cause;
		r = '0;
		produced = 1'b0;
		cause = CAUSE_NONE;
		case (frame_phase)
			PH_ADDR: begin
				addr_acc = addr_acc | ({40'd0, b} << (8 * (byte_cnt % 6)));
				frame_sum += b;
				byte_cnt += 8'd1;
				if (byte_cnt >= ADDR_BYTES)
					frame_phase = PH_START2;
			end
			PH_START2: begin
				if (b != START_BYTE) begin
					cause = CAUSE_START2;
				end else begin
					frame_sum += b;
					frame_phase = PH_CTRL;
				end
			end
			PH_CTRL: begin
				ctrl_seen = b;
				frame_sum += b;
				frame_phase = PH_LEN;
			end
			PH_LEN: begin
				len_seen = b;
				frame_sum += b;
				byte_cnt = '0;
				frame_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				r.kind = KIND_DATA;
				r.value = b - DATA_OFFSET;
				r.index = byte_cnt;
				produced = 1'b1;
				frame_sum += b;
				byte_cnt += 8'd1;
				if (byte_cnt >= len_seen)
					frame_phase = PH_SUM;
			end
			PH_SUM: begin
				if (b != frame_sum)
					cause = CAUSE_CHECKSUM;
				else
					frame_phase = PH_END;
			end
			PH_END: begin
				if (b != END_BYTE) begin
					cause = CAUSE_END;
				end else begin
					r.kind = KIND_ACCEPT;
					r.ctrl = ctrl_seen;
					r.length = len_seen;
					r.own_match = (addr_acc == own_addr);
					r.bcast_match = (addr_acc == ADDR_BROADCAST);
					r.wild_match = (addr_acc == ADDR_WILDCARD);
					produced = 1'b1;
					frame_phase = PH_HUNT;
				end
			end
			default: begin
				if (b == START_BYTE)
					open_frame();
				else
					frame_phase = PH_HUNT;
			end
		endcase
		// a failing 0x68 opens the next frame straight away
		if (cause != CAUSE_NONE) begin
			r.kind = KIND_REJECT;
			r.cause = cause;
			produced = 1'b1;
			if (b == START_BYTE)
				open_frame();
			else
				frame_phase = PH_HUNT;
		end
		if (produced)
			pending_results.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [47:0] pick_address();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0, 1: return own_addr;
			2: return ADDR_BROADCAST;
			3: return ADDR_WILDCARD;
			4: return own_addr ^ ({47'd0, 1'b1} << $urandom_range(0, 47));
			5: return ADDR_WILDCARD ^ ({47'd0, 1'b1} << $urandom_range(0, 47));
			default: return w[47:0];
		endcase
	endfunction

	function automatic logic [7:0] pick_data();
		case ($urandom_range(0, 7))
			0: return DATA_OFFSET;
			1: return DATA_OFFSET - 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 8'($urandom_range(0, 3));
		if (r < 90)
			return 8'($urandom_range(4, 8));
		if (r < 99)
			return 8'($urandom_range(9, 40));
		return 8'd255;
	endfunction

	function automatic flaw_t pick_flaw();
		case ($urandom_range(0, 9))
			0: return FLAW_START2;
			1: return FLAW_SUM;
			2: return FLAW_END;
			default: return FLAW_NONE;
		endcase
	endfunction

	// one beat on the input channel, called at a rising edge
	task automatic send_byte(input logic [7:0] b);
		bit taken;
		int gap;
		rx_byte <= b;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		parse_byte(b);
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [47:0] addr, input logic [7:0] ctrl,
			input logic [7:0] len, input flaw_t flaw, input bit fail_on_start,
			input bit with_start, output bit left_open);
		logic [7:0] sum;
		logic [7:0] b;
		int i;
		left_open = 1'b0;
		sum = START_BYTE;
		if (with_start)
			send_byte(START_BYTE);
		for (i = 0; i < ADDR_BYTES; i++) begin
			b = addr[8 * i +: 8];
			sum += b;
			send_byte(b);
		end
		if (flaw == FLAW_START2) begin
			do b = 8'($urandom_range(0, 255)); while (b == START_BYTE);
			send_byte(b);
			return;
		end
		sum += START_BYTE;
		send_byte(START_BYTE);
		sum += ctrl;
		send_byte(ctrl);
		sum += len;
		send_byte(len);
		for (i = 0; i < len; i++) begin
			b = pick_data();
			sum += b;
			send_byte(b);
		end
		if (flaw == FLAW_SUM) begin
			if (fail_on_start && sum != START_BYTE)
				b = START_BYTE;
			else
				b = sum + 8'($urandom_range(1, 255));
			left_open = (b == START_BYTE);
			send_byte(b);
			return;
		end
		send_byte(sum);
		if (flaw == FLAW_END) begin
			if (fail_on_start)
				b = START_BYTE;
			else
				do b = 8'($urandom_range(0, 255)); while (b == END_BYTE);
			left_open = (b == START_BYTE);
			send_byte(b);
			return;
		end
		send_byte(END_BYTE);
	endtask

	// sender stops until every expected result is back, then lets the pipe empty
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_own_address(input logic [47:0] v);
		drain_results();
		cfg_data <= v;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write <= 1'b0;
		own_addr = v;
	endtask

	task automatic test_reset_address();
		bit open;
		send_frame(ADDR_RESET, 8'h91, 8'd2, FLAW_NONE, 1'b0, 1'b1, open);
		send_frame(48'h0000_0000_0002, 8'h11, 8'd1, FLAW_NONE, 1'b0, 1'b1, open);
	endtask

	task automatic test_match_flags();
		bit open;
		send_frame(ADDR_BROADCAST, 8'h00, 8'd0, FLAW_NONE, 1'b0, 1'b1, open);
		send_frame(ADDR_WILDCARD, 8'hFF, 8'd1, FLAW_NONE, 1'b0, 1'b1, open);
		send_frame(48'hFFFF_FFFF_FFFF, 8'h68, 8'd3, FLAW_NONE, 1'b0, 1'b1, open);
	endtask

	task automatic test_frame_faults();
		bit open;
		// noise while hunting
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(own_addr, 8'h11, 8'd1, FLAW_START2, 1'b0, 1'b1, open);
		send_frame(own_addr, 8'h11, 8'd1, FLAW_SUM, 1'b0, 1'b1, open);
		send_frame(own_addr, 8'h11, 8'd0, FLAW_END, 1'b0, 1'b1, open);
		send_frame(own_addr, 8'h11, 8'd1, FLAW_SUM, 1'b1, 1'b1, open);
		send_frame(own_addr, 8'h14, 8'd0, FLAW_NONE, 1'b0, !open, open);
		send_frame(ADDR_BROADCAST, 8'h08, 8'd0, FLAW_END, 1'b1, 1'b1, open);
		send_frame(own_addr, 8'h91, 8'd1, FLAW_NONE, 1'b0, !open, open);
	endtask

	task automatic test_longest_frame();
		bit open;
		send_frame(pick_address(), 8'h91, 8'd255, FLAW_NONE, 1'b0, 1'b1, open);
	endtask

	task automatic test_address_config();
		logic [47:0] vals[5];
		logic [63:0] w;
		bit open;
		w = {$urandom, $urandom};
		vals[0] = '0;
		vals[1] = 48'hFFFF_FFFF_FFFF;
		vals[2] = ADDR_BROADCAST;
		vals[3] = ADDR_WILDCARD;
		vals[4] = w[47:0];
		foreach (vals[k]) begin
			write_own_address(vals[k]);
			send_frame(own_addr, 8'h11, 8'd1, FLAW_NONE, 1'b0, 1'b1, open);
			send_frame(pick_address(), 8'h11, 8'd0, FLAW_NONE, 1'b0, 1'b1, open);
		end
	endtask

	task automatic test_backpressure();
		bit open;
		hold_request = 1'b1;
		send_frame(pick_address(), 8'h91, 8'd24, FLAW_NONE, 1'b0, 1'b1, open);
		send_frame(pick_address(), 8'h91, 8'd8, FLAW_NONE, 1'b0, 1'b1, open);
		drain_results();
	endtask

	task automatic test_sender_pause();
		bit open;
		send_frame(pick_address(), 8'h11, 8'd4, FLAW_NONE, 1'b0, 1'b1, open);
		drain_results();
		send_frame(pick_address(), 8'h11, 8'd4, FLAW_NONE, 1'b0, 1'b1, open);
	endtask

	task automatic test_random_traffic();
		int    first;
		int    frames;
		bit    open;
		flaw_t flaw;
		bit    on_start;
		logic [63:0] w;
		first = bytes_sent;
		frames = 0;
		open = 1'b0;
		while (bytes_sent - first < RANDOM_BYTES) begin
			gaps_on = ($urandom_range(0, 5) != 0);
			if ($urandom_range(0, 7) == 0) begin
				// junk, sometimes with stray start bytes
				repeat ($urandom_range(1, 6))
					send_byte(($urandom_range(0, 3) == 0) ? START_BYTE
						: 8'($urandom_range(0, 255)));
				open = 1'b0;
			end else begin
				flaw = pick_flaw();
				on_start = 1'($urandom_range(0, 1));
				send_frame(pick_address(), 8'($urandom_range(0, 255)), pick_length(),
					flaw, on_start, !(open && $urandom_range(0, 4) != 0), open);
			end
			frames++;
			if (frames % 40 == 0) begin
				w = {$urandom, $urandom};
				case ($urandom_range(0, 3))
					0: write_own_address('0);
					1: write_own_address(48'hFFFF_FFFF_FFFF);
					default: write_own_address(w[47:0]);
				endcase
			end
		end
		gaps_on = 1'b1;
	endtask

	// receiver side: random stalls, one long hold on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// output beat is taken at the next rising edge; sampled at the falling edge before it
	always @(negedge clk) begin
		res_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected, out_kind %0d", out_kind);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_kind", 32'(want.kind), 32'(out_kind));
				check_field("data_value", 32'(want.value), 32'(data_value));
				check_field("data_index", 32'(want.index), 32'(data_index));
				check_field("ctrl_code", 32'(want.ctrl), 32'(ctrl_code));
				check_field("data_length", 32'(want.length), 32'(data_length));
				check_field("own_match", 32'(want.own_match), 32'(own_match));
				check_field("broadcast_match", 32'(want.bcast_match),
					32'(broadcast_match));
				check_field("wildcard_match", 32'(want.wild_match),
					32'(wildcard_match));
				check_field("reject_cause", 32'(want.cause), 32'(reject_cause));
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_address();
		test_match_flags();
		test_frame_faults();
		test_longest_frame();
		test_address_config();
		test_backpressure();
		test_sender_pause();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
